@@ design/kid_pkg.sv @@
// Package for the key instance distributor: widths, codes, slot entry type,
// sequencer states and the letter-band lookup tables. No dependencies.
package kid_pkg;

  localparam int FREE_W     = 16;  // free-entry count per slot
  localparam int CNT_W      = 5;   // instance count, active count, scan index
  localparam int MODE_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int SLOT_OUT_W = 4;   // slot index on the ports
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int BAND_W     = 5;

  localparam logic [CHAR_W-1:0] CHAR_UC_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UC_Z = 8'h5a;
  localparam logic [CHAR_W-1:0] CHAR_LC_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LC_Z = 8'h7a;
  localparam logic [CHAR_W-1:0] CASE_OFS  = 8'h20;

  // Distribution modes
  localparam logic [MODE_W-1:0] MODE_ROUND_ROBIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MOST_FREE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_KEY_RANGE   = 2'd2;

  // Request types
  localparam logic REQ_PICK   = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_MODE      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSTANCE_COUNT = 1'd1;

  typedef struct packed {
    logic              active;
    logic [FREE_W-1:0] free;
  } slot_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RR_FIX,
    ST_RR_RD,
    ST_RR_CHK,
    ST_KR_DIV,
    ST_KR_WALK
  } kid_state_t;

  // Letters per band: ceil(26 / active_count)
  function automatic logic [BAND_W-1:0] band_of(input logic [CNT_W-1:0] a);
    logic [BAND_W-1:0] b;
    b = 5'd1;
    unique case (a)
      5'd0, 5'd1: b = 5'd26;
      5'd2:       b = 5'd13;
      5'd3:       b = 5'd9;
      5'd4:       b = 5'd7;
      5'd5:       b = 5'd6;
      5'd6:       b = 5'd5;
      5'd7, 5'd8: b = 5'd4;
      5'd9, 5'd10, 5'd11, 5'd12: b = 5'd3;
      5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19,
      5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25: b = 5'd2;
      default:    b = 5'd1;
    endcase
    return b;
  endfunction

  // Upper cap on the band index: floor(26 / band)
  function automatic logic [BAND_W-1:0] quot26_of(input logic [BAND_W-1:0] band);
    logic [BAND_W-1:0] q;
    q = 5'd26;
    unique case (band)
      5'd26:   q = 5'd1;
      5'd13:   q = 5'd2;
      5'd9:    q = 5'd2;
      5'd7:    q = 5'd3;
      5'd6:    q = 5'd4;
      5'd5:    q = 5'd5;
      5'd4:    q = 5'd6;
      5'd3:    q = 5'd8;
      5'd2:    q = 5'd13;
      default: q = 5'd26;
    endcase
    return q;
  endfunction

endpackage

@@ design/kid_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module kid_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/kid_slot_table.sv @@
// Slot status table: RAM of {active, free} per slot plus per-entry written
// flags so unwritten slots read as inactive with zero free. Uses kid_pkg, kid_ram.
module kid_slot_table #(
  parameter int N_SLOTS = 16
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              wr_en,
  input  logic [((N_SLOTS > 1) ? $clog2(N_SLOTS) : 1)-1:0] wr_addr,
  input  kid_pkg::slot_entry_t                              wr_entry,
  input  logic                                              rd_en,
  input  logic [((N_SLOTS > 1) ? $clog2(N_SLOTS) : 1)-1:0] rd_addr,
  output kid_pkg::slot_entry_t                              rd_entry
);
  import kid_pkg::*;

  localparam int EW = FREE_W + 1;

  logic [N_SLOTS-1:0] written_r;
  logic [N_SLOTS-1:0] written_nxt;
  logic               rd_written_r;
  logic [EW-1:0]      ram_rdata;

  kid_ram #(
    .WIDTH (EW),
    .DEPTH (N_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_entry),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Mark an entry written on its first update
  always_comb begin
    written_nxt = written_r;
    if (wr_en) begin
      written_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else begin
      written_r <= written_nxt;
    end
  end

  // Sample the written flag alongside the RAM read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_written_r <= written_r[rd_addr];
    end
  end

  // Unwritten entries read as the reset value
  assign rd_entry = rd_written_r ? slot_entry_t'(ram_rdata) : '0;

endmodule

@@ design/kid_seq.sv @@
// Pick sequencer: scans the slot table, then runs round robin, most-free or
// key-range selection and emits one result per pick. Uses kid_pkg.
module kid_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              in_req_type,
  input  logic [kid_pkg::CHAR_W-1:0]        in_key_first_char,
  input  logic [kid_pkg::MODE_W-1:0]        dist_mode,
  input  logic [kid_pkg::CNT_W-1:0]         n_eff,
  output logic                              rd_en,
  output logic [kid_pkg::CNT_W-1:0]         rd_idx,
  input  kid_pkg::slot_entry_t              rd_entry,
  output logic                              busy,
  output logic                              out_valid,
  output logic                              out_found,
  output logic [kid_pkg::SLOT_OUT_W-1:0]    out_chosen_slot
);
  import kid_pkg::*;

  kid_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;        // next slot to read
  logic                pend_r, pend_nxt;      // read data arrives this cycle
  logic [CNT_W-1:0]    pidx_r, pidx_nxt;      // slot of arriving data
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;        // active slots seen
  logic                have_r, have_nxt;
  logic [CNT_W-1:0]    best_r, best_nxt;
  logic [FREE_W-1:0]   best_free_r, best_free_nxt;
  logic [CNT_W-1:0]    ptr_r, ptr_nxt;        // round-robin pointer
  logic [CNT_W-1:0]    wrap_r, wrap_nxt;      // stale pointer reduction
  logic [CHAR_W-1:0]   key_r, key_nxt;
  logic [BAND_W-1:0]   rem_r, rem_nxt;        // letter remainder
  logic [BAND_W-1:0]   band_r, band_nxt;
  logic [BAND_W-1:0]   quo_r, quo_nxt;
  logic [BAND_W-1:0]   last_r, last_nxt;
  logic [BAND_W-1:0]   tgt_r, tgt_nxt;        // wanted rank
  logic [CNT_W-1:0]    rank_r, rank_nxt;
  logic                ov_r, ov_nxt;
  logic                found_r, found_nxt;
  logic [CNT_W-1:0]    slot_r, slot_nxt;

  logic                accept_pick;
  logic                scan_done;
  logic [CHAR_W-1:0]   lc_key;
  logic                is_letter;
  logic                ptr_stale;
  logic [CNT_W:0]      ptr_inc;
  logic [CNT_W-1:0]    ptr_adv;
  logic [BAND_W-1:0]   band_sel;
  logic [BAND_W-1:0]   quot_sel;
  logic [BAND_W-1:0]   a_minus1;

  assign accept_pick = start && (state_r == ST_IDLE) && (in_req_type == REQ_PICK);
  assign scan_done   = !pend_r && (idx_r >= n_eff);

  // Lowercase the key and check for a letter
  assign lc_key    = ((key_r >= CHAR_UC_A) && (key_r <= CHAR_UC_Z)) ? key_r + CASE_OFS
                                                                     : key_r;
  assign is_letter = (lc_key >= CHAR_LC_A) && (lc_key <= CHAR_LC_Z);

  // Round-robin pointer helpers
  assign ptr_stale = (ptr_r >= n_eff);
  assign ptr_inc   = {1'b0, ptr_r} + 1'b1;
  assign ptr_adv   = (ptr_inc == {1'b0, n_eff}) ? '0 : ptr_inc[CNT_W-1:0];

  // Band size and last band index from the active count
  assign band_sel = band_of(cnt_r);
  assign quot_sel = quot26_of(band_sel);
  assign a_minus1 = BAND_W'(cnt_r - 1'b1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept_pick) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          priority if (cnt_r == '0) begin
            state_nxt = ST_IDLE;
          end else if (dist_mode == MODE_ROUND_ROBIN) begin
            state_nxt = ptr_stale ? ST_RR_FIX : ST_RR_RD;
          end else if ((dist_mode == MODE_KEY_RANGE) && is_letter) begin
            state_nxt = ST_KR_DIV;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RR_FIX: begin
        if (wrap_r < n_eff) begin
          state_nxt = ST_RR_RD;
        end
      end
      ST_RR_RD: begin
        state_nxt = ST_RR_CHK;
      end
      ST_RR_CHK: begin
        state_nxt = rd_entry.active ? ST_IDLE : ST_RR_RD;
      end
      ST_KR_DIV: begin
        if (rem_r < band_r) begin
          state_nxt = ST_KR_WALK;
        end
      end
      ST_KR_WALK: begin
        if ((pend_r && rd_entry.active && (BAND_W'(rank_r) == tgt_r)) || scan_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and outputs
  always_comb begin
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = idx_r;
    cnt_nxt       = cnt_r;
    have_nxt      = have_r;
    best_nxt      = best_r;
    best_free_nxt = best_free_r;
    ptr_nxt       = ptr_r;
    wrap_nxt      = wrap_r;
    key_nxt       = key_r;
    rem_nxt       = rem_r;
    band_nxt      = band_r;
    quo_nxt       = quo_r;
    last_nxt      = last_r;
    tgt_nxt       = tgt_r;
    rank_nxt      = rank_r;
    ov_nxt        = 1'b0;
    found_nxt     = found_r;
    slot_nxt      = slot_r;
    rd_en         = 1'b0;
    rd_idx        = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept_pick) begin
          idx_nxt  = '0;
          cnt_nxt  = '0;
          have_nxt = 1'b0;
          best_nxt = '0;
          key_nxt  = in_key_first_char;
        end
      end

      ST_SCAN: begin
        // Stream reads over the slots, count actives and track the largest free
        if (idx_r < n_eff) begin
          rd_en    = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r && rd_entry.active) begin
          cnt_nxt = cnt_r + 1'b1;
          if (!have_r || (best_free_r < rd_entry.free)) begin
            have_nxt      = 1'b1;
            best_nxt      = pidx_r;
            best_free_nxt = rd_entry.free;
          end
        end
        if (scan_done) begin
          wrap_nxt = ptr_inc[CNT_W-1:0];
          rem_nxt  = BAND_W'(lc_key - CHAR_LC_A);
          band_nxt = band_sel;
          quo_nxt  = '0;
          last_nxt = (a_minus1 < quot_sel) ? a_minus1 : quot_sel;
          if ((cnt_r == '0) || (dist_mode == MODE_ROUND_ROBIN)
              || ((dist_mode == MODE_KEY_RANGE) && is_letter)) begin
            if (cnt_r == '0) begin
              ov_nxt    = 1'b1;
              found_nxt = 1'b0;
              slot_nxt  = '0;
            end
          end else begin
            // Most free gives its answer now; other modes find nothing
            ov_nxt    = 1'b1;
            found_nxt = (dist_mode == MODE_MOST_FREE);
            slot_nxt  = (dist_mode == MODE_MOST_FREE) ? best_r : '0;
          end
        end
      end

      ST_RR_FIX: begin
        // Reduce the stale pointer plus one modulo the count
        if (wrap_r >= n_eff) begin
          wrap_nxt = wrap_r - n_eff;
        end else begin
          ptr_nxt = wrap_r;
        end
      end

      ST_RR_RD: begin
        rd_en  = 1'b1;
        rd_idx = ptr_r;
      end

      ST_RR_CHK: begin
        // Advance past the slot just read; take it if active
        ptr_nxt = ptr_adv;
        if (rd_entry.active) begin
          ov_nxt    = 1'b1;
          found_nxt = 1'b1;
          slot_nxt  = ptr_r;
        end
      end

      ST_KR_DIV: begin
        // Divide the letter offset by the band size, one subtraction a cycle
        if (rem_r >= band_r) begin
          rem_nxt = rem_r - band_r;
          quo_nxt = quo_r + 1'b1;
        end else begin
          tgt_nxt  = (quo_r > last_r) ? last_r : quo_r;
          idx_nxt  = '0;
          rank_nxt = '0;
        end
      end

      ST_KR_WALK: begin
        // Count active slots in order until the wanted rank
        if (idx_r < n_eff) begin
          rd_en    = 1'b1;
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end
        if (pend_r && rd_entry.active) begin
          if (BAND_W'(rank_r) == tgt_r) begin
            ov_nxt    = 1'b1;
            found_nxt = 1'b1;
            slot_nxt  = pidx_r;
          end else begin
            rank_nxt = rank_r + 1'b1;
          end
        end else if (scan_done) begin
          ov_nxt    = 1'b1;
          found_nxt = 1'b0;
          slot_nxt  = '0;
        end
      end

      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= 1'b0;
      ptr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      ptr_r   <= ptr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pidx_r      <= pidx_nxt;
    cnt_r       <= cnt_nxt;
    have_r      <= have_nxt;
    best_r      <= best_nxt;
    best_free_r <= best_free_nxt;
    wrap_r      <= wrap_nxt;
    key_r       <= key_nxt;
    rem_r       <= rem_nxt;
    band_r      <= band_nxt;
    quo_r       <= quo_nxt;
    last_r      <= last_nxt;
    tgt_r       <= tgt_nxt;
    rank_r      <= rank_nxt;
    found_r     <= found_nxt;
    slot_r      <= slot_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = ov_r;
  assign out_found       = found_r;
  assign out_chosen_slot = SLOT_OUT_W'(slot_r);

endmodule

@@ design/key_instance_distributor.sv @@
// Top level of the key instance distributor: configuration registers, slot
// table and pick sequencer. Uses kid_pkg, kid_slot_table, kid_seq.
//
// Usage:
//   Input: a transaction is taken at a clock edge with start high and busy
//   low. An update (in_req_type 1) writes the slot's active flag and free
//   count into the slot RAM in that same edge; busy stays low, so updates
//   may follow every cycle. A pick (in_req_type 0) raises busy until its
//   result is out.
//   Output: each pick gives one result on out_found / out_chosen_slot,
//   shown for one cycle with out_valid high; the receiver cannot stall it.
//   A pick first reads the slot RAM one entry a cycle over the effective
//   instance count (at most 16 here); most-free answers then. Round robin
//   reduces a stale pointer modulo the count by repeated subtraction, then
//   reads and checks each slot it visits. Key range with a letter key adds a
//   division by repeated subtraction and a second pass. The result shows the
//   cycle after busy ends, when a new transaction may start.
//   Reset clears the configuration, the round-robin pointer and the per-slot
//   written flags, so every slot reads inactive with zero free entries.
//   Configuration writes (cfg_we) take effect at once and must be made while
//   idle by the user; the block itself does not enforce it.
module key_instance_distributor #(
  parameter int N_SLOTS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_req_type,
  input  logic [kid_pkg::CHAR_W-1:0]         in_key_first_char,
  input  logic [kid_pkg::SLOT_OUT_W-1:0]     in_slot_index,
  input  logic                               in_slot_is_active,
  input  logic [kid_pkg::FREE_W-1:0]         in_slot_free,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [kid_pkg::SLOT_OUT_W-1:0]     out_chosen_slot,
  input  logic                               cfg_we,
  input  logic [kid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kid_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import kid_pkg::*;

  localparam int SLOT_W = (N_SLOTS > 1) ? $clog2(N_SLOTS) : 1;

  logic [MODE_W-1:0] dist_mode_r, dist_mode_nxt;
  logic [CNT_W-1:0]  inst_count_r, inst_count_nxt;
  logic [CNT_W-1:0]  n_eff;
  logic              wr_en;
  slot_entry_t       wr_entry;
  logic              rd_en;
  logic [CNT_W-1:0]  rd_idx;
  slot_entry_t       rd_entry;

  // Configuration writes
  always_comb begin
    dist_mode_nxt  = dist_mode_r;
    inst_count_nxt = inst_count_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIST_MODE:      dist_mode_nxt  = cfg_wdata[MODE_W-1:0];
        CFG_INSTANCE_COUNT: inst_count_nxt = cfg_wdata[CNT_W-1:0];
        default:            dist_mode_nxt  = dist_mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_mode_r  <= '0;
      inst_count_r <= '0;
    end else begin
      dist_mode_r  <= dist_mode_nxt;
      inst_count_r <= inst_count_nxt;
    end
  end

  // Saturate the instance count to the table depth
  assign n_eff = (32'(inst_count_r) > N_SLOTS) ? CNT_W'(N_SLOTS) : inst_count_r;

  // Update transactions write straight into the table while idle
  assign wr_en           = start && !busy && (in_req_type == REQ_UPDATE)
                           && (32'(in_slot_index) < N_SLOTS);
  assign wr_entry.active = in_slot_is_active;
  assign wr_entry.free   = in_slot_free;

  kid_slot_table #(
    .N_SLOTS (N_SLOTS)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (SLOT_W'(in_slot_index)),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (SLOT_W'(rd_idx)),
    .rd_entry (rd_entry)
  );

  kid_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .in_req_type       (in_req_type),
    .in_key_first_char (in_key_first_char),
    .dist_mode         (dist_mode_r),
    .n_eff             (n_eff),
    .rd_en             (rd_en),
    .rd_idx            (rd_idx),
    .rd_entry          (rd_entry),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_chosen_slot   (out_chosen_slot)
  );

endmodule

@@ test/tb_top.sv @@
// Testbench for key_instance_distributor: directed and random slot updates and
// picks over all modes, checked against a behavioral predictor of the slot picker.
// Depends on kid_pkg and the key_instance_distributor RTL.
`timescale 1ns / 1ps

module tb_top;
  import kid_pkg::*;

  localparam int SLOT_COUNT     = 16;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 120;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic                  req_type;
    logic [CHAR_W-1:0]     key;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  active;
    logic [FREE_W-1:0]     free;
  } dist_req_t;

  typedef struct packed {
    logic                  found;
    logic [SLOT_OUT_W-1:0] slot;
  } choice_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  in_req_type = 1'b0;
  logic [CHAR_W-1:0]     in_key_first_char = '0;
  logic [SLOT_OUT_W-1:0] in_slot_index = '0;
  logic                  in_slot_is_active = 1'b0;
  logic [FREE_W-1:0]     in_slot_free = '0;
  logic                  out_valid;
  logic                  out_found;
  logic [SLOT_OUT_W-1:0] out_chosen_slot;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  dist_req_t request_queue[$];
  choice_t   expected_choices[$];
  logic      taken = 1'b0;
  int        idle_pct = 0;
  int        err_count = 0;
  int        quiet_cycles = 0;

  // Predictor copy of the slot table, pointer and configuration
  logic              slot_act[SLOT_COUNT];
  logic [FREE_W-1:0] slot_free_cnt[SLOT_COUNT];
  int                rr_ptr;
  logic [MODE_W-1:0] dist_mode;
  logic [4:0]        inst_count;

  key_instance_distributor #(.N_SLOTS(SLOT_COUNT)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_key_first_char (in_key_first_char),
    .in_slot_index     (in_slot_index),
    .in_slot_is_active (in_slot_is_active),
    .in_slot_free      (in_slot_free),
    .out_valid         (out_valid),
    .out_found         (out_found),
    .out_chosen_slot   (out_chosen_slot),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Walk from the pointer, taking slots until an active one turns up
  function automatic int rr_take(input int n);
    int p;
    for (int steps = 0; steps <= n; steps++) begin
      p = rr_ptr;
      rr_ptr = (p + 1) % n;
      if (p < n && slot_act[p]) return p;
    end
    return 0;
  endfunction

  // Work out the slot a pick chooses under the current mode and table
  function automatic choice_t predict_choice(input logic [CHAR_W-1:0] key);
    int n, a, c, band, last, idx, rank, best;
    logic have;
    choice_t r;
    r = '0;
    n = (inst_count > SLOT_COUNT) ? SLOT_COUNT : int'(inst_count);
    a = 0;
    for (int i = 0; i < n; i++) a += slot_act[i] ? 1 : 0;
    if (a > 0) begin
      case (dist_mode)
        MODE_ROUND_ROBIN: begin
          r.slot  = SLOT_OUT_W'(rr_take(n));
          r.found = 1'b1;
        end
        MODE_MOST_FREE: begin
          best = 0;
          have = 1'b0;
          for (int i = 0; i < n; i++) begin
            if (slot_act[i] && (!have || slot_free_cnt[best] < slot_free_cnt[i])) begin
              best = i;
              have = 1'b1;
            end
          end
          r.slot  = SLOT_OUT_W'(best);
          r.found = 1'b1;
        end
        MODE_KEY_RANGE: begin
          c = int'(key);
          if (c >= CHAR_UC_A && c <= CHAR_UC_Z) c = c + CASE_OFS;
          if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
            band = (26 + a - 1) / a;
            last = 26 / band;
            if (a - 1 < last) last = a - 1;
            idx = (c - CHAR_LC_A) / band;
            if (idx > last) idx = last;
            rank = 0;
            for (int i = 0; i < n; i++) begin
              if (slot_act[i]) begin
                if (rank == idx && !r.found) begin
                  r.slot  = SLOT_OUT_W'(i);
                  r.found = 1'b1;
                end
                rank++;
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (!r.found) r.slot = '0;
    return r;
  endfunction

  function automatic void queue_pick(input logic [CHAR_W-1:0] key);
    dist_req_t t;
    t = '0;
    t.req_type = REQ_PICK;
    t.key      = key;
    t.slot     = SLOT_OUT_W'($urandom);
    t.free     = FREE_W'($urandom);
    request_queue.push_back(t);
  endfunction

  function automatic void queue_update(input logic [SLOT_OUT_W-1:0] slot, input logic act,
                                       input logic [FREE_W-1:0] free);
    dist_req_t t;
    t.req_type = REQ_UPDATE;
    t.key      = CHAR_W'($urandom);
    t.slot     = slot;
    t.active   = act;
    t.free     = free;
    request_queue.push_back(t);
  endfunction

  // Configuration write, one cycle of cfg_we
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Hold until all transactions are out and every pick has answered, then settle
  task automatic drain();
    do @(negedge clk);
    while (request_queue.size() != 0 || start || expected_choices.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Driver: present the next transaction once the current one is taken
  always @(negedge clk) begin
    dist_req_t t;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (request_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        t = request_queue.pop_front();
        start             <= 1'b1;
        in_req_type       <= t.req_type;
        in_key_first_char <= t.key;
        in_slot_index     <= t.slot;
        in_slot_is_active <= t.active;
        in_slot_free      <= t.free;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: track config writes, check results, predict accepted transactions
  always @(posedge clk) begin
    choice_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_act[i]      = 1'b0;
        slot_free_cnt[i] = '0;
      end
      rr_ptr     = 0;
      dist_mode  = MODE_ROUND_ROBIN;
      inst_count = '0;
      taken <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DIST_MODE) dist_mode = cfg_wdata[MODE_W-1:0];
        else if (cfg_index == CFG_INSTANCE_COUNT) inst_count = cfg_wdata;
      end
      if (out_valid) begin
        if (expected_choices.size() == 0) begin
          $display("%0t: unexpected result found=%0d slot=%0d", $time, out_found,
                   out_chosen_slot);
          err_count++;
        end else begin
          want = expected_choices.pop_front();
          if (out_found !== want.found) begin
            $display("%0t: found mismatch: expected %0d, actual %0d", $time, want.found,
                     out_found);
            err_count++;
          end
          if (out_chosen_slot !== want.slot) begin
            $display("%0t: chosen_slot mismatch: expected %0d, actual %0d", $time,
                     want.slot, out_chosen_slot);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        taken <= 1'b1;
        if (in_req_type == REQ_UPDATE) begin
          slot_act[in_slot_index]      = in_slot_is_active;
          slot_free_cnt[in_slot_index] = in_slot_free;
        end else begin
          expected_choices.push_back(predict_choice(in_key_first_char));
        end
      end else begin
        taken <= 1'b0;
      end
      // Watchdog over cycles with no transaction in either direction
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $time);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Stimulus: directed corners, then random phases over modes, counts and idling
  initial begin
    int n;
    logic [MODE_W-1:0] m;
    logic [4:0] cnt;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Count of zero right after reset: nothing to pick
    queue_pick("a");
    drain();
    write_cfg(CFG_INSTANCE_COUNT, 5'd16);
    // No active slot: pointer must stay put
    queue_pick("a");
    queue_update(4'd0, 1'b1, 16'h0000);
    queue_update(4'd15, 1'b1, 16'hFFFF);
    queue_update(4'd7, 1'b1, 16'hFFFF);
    repeat (4) queue_pick(8'h00);
    drain();
    // Tie on the largest free count goes to the lower slot
    write_cfg(CFG_DIST_MODE, {3'b000, MODE_MOST_FREE});
    queue_pick(8'hFF);
    drain();
    // Letter bands: both cases, both ends, and neighbors of the letters
    write_cfg(CFG_DIST_MODE, {3'b111, MODE_KEY_RANGE});
    queue_pick("A");
    queue_pick("Z");
    queue_pick("a");
    queue_pick("z");
    queue_pick("m");
    queue_pick("@");
    queue_pick("[");
    queue_pick("{");
    queue_pick(8'hFF);
    drain();
    // Unused mode value
    write_cfg(CFG_DIST_MODE, 5'b11111);
    queue_pick("q");
    drain();
    // Saturated count, then a shrunk count that leaves the pointer stale
    write_cfg(CFG_DIST_MODE, {3'b000, MODE_ROUND_ROBIN});
    write_cfg(CFG_INSTANCE_COUNT, 5'd31);
    queue_pick(8'h00);
    queue_update(4'd2, 1'b0, 16'h1234);
    drain();
    write_cfg(CFG_INSTANCE_COUNT, 5'd4);
    queue_pick(8'h00);
    queue_pick(8'h00);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 71;
        default: idle_pct = 13;
      endcase
      m = (ph == 7) ? MODE_UNUSED : MODE_W'(ph % 3);
      if (ph % 4 == 0)  cnt = 5'd16;
      else if (ph == 5) cnt = 5'd31;
      else if (ph == 9) cnt = 5'd0;
      else              cnt = 5'($urandom_range(1, 16));
      write_cfg(CFG_DIST_MODE, {3'($urandom_range(7)), m});
      write_cfg(CFG_INSTANCE_COUNT, cnt);
      n = (cnt > SLOT_COUNT) ? SLOT_COUNT : int'(cnt);
      // Populate a few slots so picks get past the empty case
      repeat (5) queue_update(4'($urandom_range(0, (n > 0) ? n - 1 : 15)), 1'b1,
                              16'($urandom));
      repeat (55) begin
        if ($urandom_range(99) < 30) begin
          queue_update(($urandom_range(99) < 80 && n > 0) ? 4'($urandom_range(0, n - 1))
                                                         : 4'($urandom),
                       $urandom_range(99) < 75,
                       ($urandom_range(99) < 10) ? 16'h0000 :
                       ($urandom_range(99) < 10) ? 16'hFFFF :
                       ($urandom_range(99) < 30) ? 16'($urandom_range(3)) : 16'($urandom));
        end else if ($urandom_range(99) < 45) begin
          queue_pick(8'($urandom_range(CHAR_LC_A, CHAR_LC_Z)));
        end else if ($urandom_range(99) < 55) begin
          queue_pick(8'($urandom_range(CHAR_UC_A, CHAR_UC_Z)));
        end else begin
          queue_pick(8'($urandom));
        end
      end
      drain();
    end

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
